// ----- rtl/core/wbps_pkg.sv -----
// shared types and constants for the wildcard byte pattern scanner
package wbps_pkg;

    // bytes that the two pattern registers hold
    localparam int REG_PATTERN_BYTES = 16;

    // configuration register indexes
    localparam logic [2:0] CFG_PATTERN_LOW  = 3'd0;
    localparam logic [2:0] CFG_PATTERN_HIGH = 3'd1;
    localparam logic [2:0] CFG_WILDCARD     = 3'd2;
    localparam logic [2:0] CFG_LENGTH       = 3'd3;
    localparam logic [2:0] CFG_BASE         = 3'd4;

    // error codes reported with the last word of a region
    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_WILD_FIRST = 2'd1,
        ERR_SHORT      = 2'd2
    } wbps_err_t;

    // decoded configuration seen by the matcher
    typedef struct packed {
        logic [REG_PATTERN_BYTES-1:0][7:0] pattern;
        logic [REG_PATTERN_BYTES-1:0]      wild;
        logic [4:0]                        len;   // effective length, clamped
        logic [63:0]                       base;
    } wbps_cfg_t;

    // one result word
    typedef struct packed {
        logic        found;
        logic [63:0] addr;
        wbps_err_t   err;
    } wbps_res_t;

endpackage

// ----- rtl/core/wbps_cfg.sv -----
// configuration registers and effective pattern length
module wbps_cfg import wbps_pkg::*; #(
    parameter int PATTERN_MAX = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output wbps_cfg_t   cfg
);

    localparam int LEN_LIM = (PATTERN_MAX < REG_PATTERN_BYTES) ? PATTERN_MAX : REG_PATTERN_BYTES;

    logic [63:0] pat_low_reg;
    logic [63:0] pat_high_reg;
    logic [15:0] wild_reg;
    logic [4:0]  len_reg;
    logic [63:0] base_reg;
    logic [4:0]  len_eff;

    assign cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            wild_reg     <= '0;
            len_reg      <= 5'd1;
            base_reg     <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_PATTERN_LOW:  pat_low_reg  <= cfg_data;
                CFG_PATTERN_HIGH: pat_high_reg <= cfg_data;
                CFG_WILDCARD:     wild_reg     <= cfg_data[15:0];
                CFG_LENGTH:       len_reg      <= cfg_data[4:0];
                CFG_BASE:         base_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // zero length acts as one, long lengths clamp to the window size
    always_comb begin
        priority if (len_reg == 5'd0) begin
            len_eff = 5'd1;
        end else if (len_reg > 5'(LEN_LIM)) begin
            len_eff = 5'(LEN_LIM);
        end else begin
            len_eff = len_reg;
        end
    end

    assign cfg.pattern = {pat_high_reg, pat_low_reg};
    assign cfg.wild    = wild_reg;
    assign cfg.len     = len_eff;
    assign cfg.base    = base_reg;

endmodule

// ----- rtl/core/wbps_match.sv -----
// byte history window, parallel masked compare and region offset counter
module wbps_match import wbps_pkg::*; #(
    parameter int PATTERN_MAX = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  wbps_cfg_t cfg,
    input  logic [7:0] cur_byte,
    input  logic      cur_last,
    input  logic      advance,
    output wbps_res_t res
);

    localparam int LEN_LIM   = (PATTERN_MAX < REG_PATTERN_BYTES) ? PATTERN_MAX : REG_PATTERN_BYTES;
    localparam int WIN_DEPTH = LEN_LIM - 1;
    localparam int IDX_W     = $clog2(LEN_LIM);

    logic [7:0]  recent_reg [WIN_DEPTH];
    logic [63:0] cnt_reg;      // offset of the current byte plus one
    logic [63:0] cnt_next;
    logic [LEN_LIM-1:0][7:0] win;
    logic        filled;
    logic        all_ok;

    // window: newest byte first
    always_comb begin
        win[0] = cur_byte;
        for (int j = 1; j < LEN_LIM; j++) begin
            win[j] = recent_reg[j-1];
        end
    end

    // compare every pattern position against its aligned window byte
    always_comb begin
        logic [4:0] pos;
        all_ok = 1'b1;
        for (int i = 0; i < LEN_LIM; i++) begin
            pos = cfg.len - 5'd1 - 5'(i);
            if ((5'(i) < cfg.len) && !cfg.wild[i] &&
                (win[pos[IDX_W-1:0]] != cfg.pattern[i])) begin
                all_ok = 1'b0;
            end
        end
    end

    assign filled = (cnt_reg >= 64'(cfg.len));

    // result word
    always_comb begin
        res.found = filled && !cfg.wild[0] && all_ok;
        res.addr  = res.found ? (cfg.base + cnt_reg - 64'(cfg.len)) : 64'd0;
        priority if (!cur_last) begin
            res.err = ERR_NONE;
        end else if (cfg.wild[0]) begin
            res.err = ERR_WILD_FIRST;
        end else if (!filled) begin
            res.err = ERR_SHORT;
        end else begin
            res.err = ERR_NONE;
        end
    end

    assign cnt_next = cur_last ? 64'd1 : (cnt_reg + 64'd1);

    // history shift and offset count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 64'd1;
            for (int k = 0; k < WIN_DEPTH; k++) begin
                recent_reg[k] <= 8'd0;
            end
        end else if (advance) begin
            cnt_reg       <= cnt_next;
            recent_reg[0] <= cur_byte;
            for (int k = 1; k < WIN_DEPTH; k++) begin
                recent_reg[k] <= recent_reg[k-1];
            end
        end
    end

endmodule

// ----- rtl/core/wildcard_byte_pattern_scanner.sv -----
// top level of the wildcard byte pattern scanner
// Scans a byte stream for a pattern of up to 16 bytes with per-byte wildcards and returns
// one result word for every input word, in order: found, the match start address
// (base plus region offset) and, on the region's last byte, an error code. The
// block takes one byte per cycle while results are accepted, and a result is valid once its word
// has moved from the input register into the result register: the parallel window compare and
// the 64-bit address adder sit between the input register and the result register. A new byte
// is taken while a finished result waits only if the input register is empty. Configuration
// writes are taken at any time but must only be issued while the block is idle.
module wildcard_byte_pattern_scanner import wbps_pkg::*; #(
    parameter int PATTERN_MAX = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // region_end
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [0] found, [64:1] match_address, [71:65] zero
    output logic        m_tlast,   // final_res
    output logic [1:0]  m_tuser    // [1:0] error_code
);

    wbps_cfg_t cfg;
    wbps_res_t res;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    logic       out_last_reg;
    wbps_res_t  res_reg;
    logic       advance;

    wbps_cfg #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    wbps_match #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_match (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .cur_byte(in_byte_reg),
        .cur_last(in_last_reg),
        .advance (advance),
        .res     (res)
    );

    // word moves from input register to result register
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg      <= res;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, res_reg.addr, res_reg.found};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = res_reg.err;

    // errors only come with the last word of a region
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != ERR_NONE)) |-> m_tlast)
        else $error("error code on a word that does not end the region");

    // a match never carries an error
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tuser == ERR_NONE))
        else $error("match reported together with an error");

    // no match means a zero address
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[64:1] == 64'd0))
        else $error("address set without a match");

    // a word leaving the input register shows up as a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("advanced word lost");

endmodule

// ----- test/wildcard_byte_pattern_scanner_tb.sv -----
// testbench for the wildcard byte pattern scanner: directed and random regions checked against a predictor
`timescale 1ns / 1ps

module wildcard_byte_pattern_scanner_tb;
    import wbps_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int WINDOW_DEPTH = 15;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } scan_word_t;

    typedef struct packed {
        logic        found;
        logic [63:0] addr;
        logic        last;
        wbps_err_t   err;
    } scan_res_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = CFG_PATTERN_LOW;
    logic [63:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    scan_word_t  pending_words[$];
    scan_res_t   expected_res[$];
    int unsigned words_queued   = 0;
    int unsigned words_taken    = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_gap       = 0;
    int unsigned stall_gap      = 0;
    bit          idle_enabled   = 1'b1;
    bit          word_taken     = 1'b0;

    // predictor copy of the registers and the scan state
    logic [63:0] sh_pat_low  = '0;
    logic [63:0] sh_pat_high = '0;
    logic [15:0] sh_wild     = '0;
    logic [4:0]  sh_len      = 5'd1;
    logic [63:0] sh_base     = '0;
    logic [7:0]  window_bytes [0:WINDOW_DEPTH-1] = '{default: 8'h00};
    logic [63:0] region_offset = '0;

    // pattern as last written, used to plant occurrences in random regions
    logic [127:0] gen_pattern = '0;
    logic [15:0]  gen_wild    = '0;
    int           gen_len     = 1;

    always #5 aclk = ~aclk;

    wildcard_byte_pattern_scanner DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // window compare for one byte, then advance the window and the region offset
    function automatic scan_res_t scan_byte(input logic [7:0] cur, input logic last);
        scan_res_t    r;
        int           len;
        int           i;
        logic [63:0]  count;
        logic [127:0] pat;
        logic [7:0]   b;
        logic         first_wild;
        logic         filled;
        logic         hit;
        len = (sh_len == 5'd0) ? 1 : (sh_len > 5'd16) ? 16 : int'(sh_len);
        count = region_offset + 64'd1;
        pat = {sh_pat_high, sh_pat_low};
        first_wild = sh_wild[0];
        filled = count >= 64'(len);
        hit = filled && !first_wild;
        for (i = 0; i < len; i++) begin
            if (!sh_wild[i]) begin
                if (i == len - 1)
                    b = cur;
                else
                    b = window_bytes[len - 2 - i];
                if (b != pat[8*i +: 8])
                    hit = 1'b0;
            end
        end
        r.found = hit;
        r.addr = hit ? sh_base + count - 64'(len) : 64'd0;
        r.last = last;
        r.err = ERR_NONE;
        if (last && first_wild)
            r.err = ERR_WILD_FIRST;
        else if (last && !filled)
            r.err = ERR_SHORT;
        for (i = WINDOW_DEPTH - 1; i > 0; i--)
            window_bytes[i] = window_bytes[i-1];
        window_bytes[0] = cur;
        region_offset = last ? 64'd0 : count;
        return r;
    endfunction

    // monitor: register writes, result check, input accept
    always @(posedge aclk) begin
        scan_res_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PATTERN_LOW:  sh_pat_low = cfg_data;
                    CFG_PATTERN_HIGH: sh_pat_high = cfg_data;
                    CFG_WILDCARD:     sh_wild = cfg_data[15:0];
                    CFG_LENGTH:       sh_len = cfg_data[4:0];
                    CFG_BASE:         sh_base = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_res.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word: found=%0b addr=%h last=%0b err=%0d",
                                 m_tdata[0], m_tdata[64:1], m_tlast, m_tuser);
                end else begin
                    want = expected_res.pop_front();
                    if (m_tdata[0] !== want.found || m_tdata[64:1] !== want.addr ||
                        m_tdata[71:65] !== 7'd0 || m_tlast !== want.last ||
                        m_tuser !== want.err) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"result word differs: expected found=%0b addr=%h last=%0b ",
                                      "err=%0d, got found=%0b addr=%h pad=%h last=%0b err=%0d"},
                                     want.found, want.addr, want.last, want.err,
                                     m_tdata[0], m_tdata[64:1], m_tdata[71:65], m_tlast, m_tuser);
                    end
                end
            end
            word_taken = s_tvalid && s_tready;
            if (word_taken) begin
                expected_res.insert(expected_res.size(), scan_byte(s_tdata, s_tlast));
                words_taken++;
            end
        end
    end

    // driver: input words with send gaps, result side stalls
    always @(negedge aclk) begin
        scan_word_t w;
        if (aresetn) begin
            if (!s_tvalid || word_taken) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    w = pending_words.pop_front();
                    s_tdata <= w.data;
                    s_tlast <= w.last;
                    s_tvalid <= 1'b1;
                    if (idle_enabled && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 12);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            if (stall_gap != 0) begin
                stall_gap--;
                m_tready <= 1'b0;
            end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
                stall_gap = $urandom_range(0, 11);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // run timeout
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("wildcard_byte_pattern_scanner: mismatch");
        $finish;
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_scan(input logic [127:0] pat, input logic [15:0] wild,
                            input logic [4:0] len_code, input logic [63:0] base_addr);
        write_reg(CFG_PATTERN_LOW, pat[63:0]);
        write_reg(CFG_PATTERN_HIGH, pat[127:64]);
        write_reg(CFG_WILDCARD, {48'd0, wild});
        write_reg(CFG_LENGTH, {59'd0, len_code});
        write_reg(CFG_BASE, base_addr);
        gen_pattern = pat;
        gen_wild = wild;
        gen_len = (len_code == 5'd0) ? 1 : (len_code > 5'd16) ? 16 : int'(len_code);
    endtask

    task automatic push_word(input logic [7:0] d, input logic last);
        pending_words.insert(pending_words.size(), scan_word_t'{d, last});
        words_queued++;
    endtask

    // block until every word is taken and every result is back
    task automatic wait_idle();
        do @(negedge aclk); while (words_taken != words_queued || expected_res.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // random region built from pattern bytes and noise, with planted occurrences
    task automatic push_random_region(input int n);
        logic [7:0] region_bytes [0:63];
        int         start;
        int         i;
        int         tries;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 1) == 1)
                region_bytes[i] = gen_pattern[8*$urandom_range(0, gen_len - 1) +: 8];
            else
                region_bytes[i] = 8'($urandom);
        end
        for (tries = 0; tries < 2; tries++) begin
            if (n >= gen_len && $urandom_range(0, 3) != 0) begin
                start = $urandom_range(0, n - gen_len);
                for (i = 0; i < gen_len; i++)
                    if (!gen_wild[i])
                        region_bytes[start + i] = gen_pattern[8*i +: 8];
            end
        end
        for (i = 0; i < n; i++)
            push_word(region_bytes[i], i == n - 1);
    endtask

    initial begin
        logic [127:0] pat;
        logic [15:0]  wild;
        logic [4:0]   len_code;
        logic [63:0]  base_addr;
        int           phase;
        int           i;
        int           n;
        int           word_count;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset registers: one byte pattern of zero
        push_word(8'h00, 1'b0); push_word(8'hFF, 1'b0); push_word(8'h00, 1'b1);
        wait_idle();

        // masked four byte pattern, start address wraps past the top
        set_scan(128'hEF00_ADDE, 16'h0004, 5'd4, 64'hFFFF_FFFF_FFFF_FFFF);
        push_word(8'h01, 1'b0); push_word(8'hDE, 1'b0); push_word(8'hAD, 1'b0);
        push_word(8'h77, 1'b0); push_word(8'hEF, 1'b1);
        // short region, then a match that would span two regions
        push_word(8'hDE, 1'b0); push_word(8'hAD, 1'b1);
        push_word(8'h77, 1'b0); push_word(8'hEF, 1'b1);
        wait_idle();

        // length zero acts as one
        set_scan(128'hDE, 16'h0000, 5'd0, 64'h1000);
        push_word(8'hDE, 1'b1);
        wait_idle();

        // wildcard first byte suppresses matches
        set_scan(128'hDE, 16'h0001, 5'd0, 64'h0);
        push_word(8'hDE, 1'b1);
        wait_idle();

        // wildcard error wins over short region, length above range
        set_scan(128'hDE, 16'h8001, 5'd31, 64'h0);
        push_word(8'hAA, 1'b0); push_word(8'hBB, 1'b1);
        wait_idle();

        // full sixteen byte pattern filling the region exactly
        set_scan({128{1'b1}}, 16'h0000, 5'd20, 64'h0);
        for (i = 0; i < 16; i++)
            push_word(8'hFF, i == 15);
        wait_idle();

        // random phases; phases 2, 6, 10 and 11 run without idling
        for (phase = 0; phase < 12; phase++) begin
            idle_enabled = (phase < 10) && (phase % 4 != 2);
            for (i = 0; i < 16; i++) begin
                case ($urandom_range(0, 3))
                    0:       pat[8*i +: 8] = 8'h00;
                    1:       pat[8*i +: 8] = 8'hFF;
                    2:       pat[8*i +: 8] = 8'h5A;
                    default: pat[8*i +: 8] = 8'($urandom);
                endcase
            end
            if ($urandom_range(0, 4) == 0)
                len_code = 5'($urandom_range(0, 31));
            else
                len_code = 5'($urandom_range(1, 6));
            wild = 16'($urandom) & 16'($urandom);
            if ($urandom_range(0, 7) != 0)
                wild[0] = 1'b0;
            if (phase == 5)
                wild = 16'hFFFF;
            if ($urandom_range(0, 3) == 0)
                base_addr = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 40));
            else
                base_addr = {$urandom, $urandom};
            set_scan(pat, wild, len_code, base_addr);
            word_count = 0;
            while (word_count < 85) begin
                if ($urandom_range(0, 5) == 0)
                    n = $urandom_range(1, gen_len);
                else
                    n = $urandom_range(1, 3 * gen_len + 10);
                push_random_region(n);
                word_count += n;
            end
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("wildcard_byte_pattern_scanner: match");
        else
            $display("wildcard_byte_pattern_scanner: mismatch");
        $finish;
    end

endmodule
